// File: hw/rtl/gbte_pkg.sv
// shared types and constants for the gap buffer text engine
package gbte_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_DEL_BACK  = 3'd1,
    CMD_DEL_FWD   = 3'd2,
    CMD_SET_CUR   = 3'd3,
    CMD_READ      = 3'd4,
    CMD_PREV_BND  = 3'd5,
    CMD_NEXT_BND  = 3'd6,
    CMD_NONE      = 3'd7
  } cmd_t;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam int unsigned MAX_SEQ  = 4;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  data_byte;
    logic [12:0] amount;
    logic [12:0] position;
  } item_t;

  typedef struct packed {
    logic        ok;
    logic [12:0] deleted;
    logic [7:0]  read_byte;
    logic [12:0] boundary;
    logic [12:0] cursor;
    logic [12:0] text_size;
  } result_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

endpackage

// File: hw/rtl/gbte_front.sv
// input stage and two-entry queue of command items
module gbte_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gbte_pkg::item_t      in_item,
  output logic                 q_valid,
  input  logic                 q_ready,
  output gbte_pkg::item_t      q_item
);

  gbte_pkg::item_t slot [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  logic            push;
  logic            pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_item;
  end

endmodule

// File: hw/rtl/gbte_back.sv
// command execution: gap registers, text memory and sequencer
module gbte_back #(
  parameter int unsigned CAPACITY = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  gbte_pkg::item_t      q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gbte_pkg::result_t    out_res
);

  localparam int unsigned AW = $clog2(CAPACITY);
  // position width covers both the capacity and the 13-bit item fields
  localparam int unsigned PW = (AW + 1 > 13) ? AW + 1 : 13;
  localparam logic [PW-1:0] CAP = PW'(CAPACITY);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MOVE  = 6'b000010,
    ST_MWR   = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_SWAIT = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rdata;
  logic [AW-1:0] raddr;
  logic          wen;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  state_t          state;
  logic [PW-1:0]   gap_front;
  logic [PW-1:0]   gap_back;
  logic [12:0]     run_left;
  logic            run_accepted;
  gbte_pkg::item_t cur;
  logic [PW-1:0]   target;
  logic [PW-1:0]   scan_pos;
  logic [PW-1:0]   scan_start;
  logic [2:0]      scan_k;
  logic            moved;
  logic            r_ok;
  logic [12:0]     r_del;
  logic [7:0]      r_byte;
  logic [12:0]     r_bnd;

  logic [PW-1:0]   size;
  logic [PW-1:0]   gap_len;
  logic [PW-1:0]   pos_in;
  logic [PW-1:0]   pos_cl;
  logic [PW-1:0]   amt;
  logic [PW-1:0]   avail_back;

  assign size       = gap_front + (CAP - gap_back);
  assign gap_len    = gap_back - gap_front;
  assign avail_back = CAP - gap_back;
  assign pos_in     = (PW'(q_item.position) > size) ? size : PW'(q_item.position);
  assign pos_cl     = pos_in;
  assign amt        = PW'(q_item.amount);
  assign q_ready    = (state == ST_IDLE) && !out_valid;

  // logical to physical address across the gap
  function automatic logic [AW-1:0] phys_of(input logic [PW-1:0] p,
                                            input logic [PW-1:0] gf,
                                            input logic [PW-1:0] gl);
    logic [PW:0] s;
    s = (p < gf) ? {1'b0, p} : ({1'b0, p} + {1'b0, gl});
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    wen   = 1'b0;
    waddr = gap_front[AW-1:0];
    wdata = q_item.data_byte;
    raddr = phys_of(scan_pos, gap_front, gap_len);
    if (state == ST_IDLE && q_valid && !out_valid && q_item.cmd == gbte_pkg::CMD_INSERT) begin
      if (run_left == 13'd0) begin
        wen = (q_item.amount != 13'd0) && (amt <= gap_len) && (gap_front < gap_back);
      end else begin
        wen = run_accepted && (gap_front < gap_back);
      end
    end
    if (state == ST_MOVE) begin
      raddr = (target < gap_front) ? AW'(gap_front - 1'b1) : gap_back[AW-1:0];
    end
    if (state == ST_MWR) begin
      wen   = 1'b1;
      wdata = rdata;
      waddr = (target < gap_front) ? AW'(gap_back - 1'b1) : gap_front[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      gap_front    <= '0;
      gap_back     <= CAP;
      run_left     <= '0;
      run_accepted <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid && !out_valid) begin
            cur    <= q_item;
            r_ok   <= 1'b0;
            r_del  <= '0;
            r_byte <= '0;
            r_bnd  <= '0;
            state  <= ST_DONE;
            case (q_item.cmd)
              gbte_pkg::CMD_INSERT: begin
                if (run_left == 13'd0) begin
                  if (q_item.amount == 13'd0) begin
                    r_ok <= 1'b1;
                  end else begin
                    run_accepted <= amt <= gap_len;
                    run_left     <= q_item.amount - 13'd1;
                    r_ok         <= amt <= gap_len;
                    if (amt <= gap_len && gap_front < gap_back)
                      gap_front <= gap_front + 1'b1;
                  end
                end else begin
                  run_left <= run_left - 13'd1;
                  r_ok     <= run_accepted;
                  if (run_accepted && gap_front < gap_back)
                    gap_front <= gap_front + 1'b1;
                end
              end
              gbte_pkg::CMD_DEL_BACK: begin
                if (amt < gap_front) begin
                  r_del     <= q_item.amount;
                  gap_front <= gap_front - amt;
                end else begin
                  r_del     <= 13'(gap_front);
                  gap_front <= '0;
                end
              end
              gbte_pkg::CMD_DEL_FWD: begin
                if (amt < avail_back) begin
                  r_del    <= q_item.amount;
                  gap_back <= gap_back + amt;
                end else begin
                  r_del    <= 13'(avail_back);
                  gap_back <= CAP;
                end
              end
              gbte_pkg::CMD_SET_CUR: begin
                target <= pos_cl;
                moved  <= pos_cl != gap_front;
                state  <= ST_MOVE;
              end
              gbte_pkg::CMD_READ: begin
                scan_pos <= pos_cl;
                scan_k   <= 3'd0;
                state    <= ST_SCAN;
              end
              gbte_pkg::CMD_PREV_BND: begin
                scan_start <= pos_cl;
                scan_k     <= 3'd0;
                if (pos_cl == '0) begin
                  r_bnd <= '0;
                end else begin
                  scan_pos <= pos_cl - 1'b1;
                  state    <= ST_SCAN;
                end
              end
              gbte_pkg::CMD_NEXT_BND: begin
                scan_k <= 3'd0;
                if (pos_cl >= size) begin
                  r_bnd <= 13'(size);
                end else if (pos_cl + 1'b1 >= size) begin
                  r_bnd <= 13'(pos_cl + 1'b1);
                end else begin
                  scan_pos <= pos_cl + 1'b1;
                  state    <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MOVE: begin
          if (target == gap_front) begin
            r_ok  <= moved;
            state <= ST_DONE;
          end else begin
            state <= ST_MWR;
          end
        end
        ST_MWR: begin
          if (target < gap_front) begin
            gap_front <= gap_front - 1'b1;
            gap_back  <= gap_back - 1'b1;
          end else begin
            gap_front <= gap_front + 1'b1;
            gap_back  <= gap_back + 1'b1;
          end
          state <= ST_MOVE;
        end
        ST_SCAN: state <= ST_SWAIT;
        ST_SWAIT: begin
          state <= ST_DONE;
          case (cur.cmd)
            gbte_pkg::CMD_READ: begin
              r_byte <= (scan_pos < size) ? rdata : 8'd0;
            end
            gbte_pkg::CMD_PREV_BND: begin
              if (!gbte_pkg::is_cont(rdata)) begin
                r_bnd <= 13'(scan_pos);
              end else if (scan_k == 3'(gbte_pkg::MAX_SEQ - 1) || scan_pos == '0) begin
                r_bnd <= 13'(scan_start - 1'b1);
              end else begin
                scan_pos <= scan_pos - 1'b1;
                scan_k   <= scan_k + 3'd1;
                state    <= ST_SCAN;
              end
            end
            default: begin
              // next boundary: stop at a lead byte, the end, or after four looks
              if (!gbte_pkg::is_cont(rdata)) begin
                r_bnd <= 13'(scan_pos);
              end else if (scan_k == 3'(gbte_pkg::MAX_SEQ - 1) ||
                           scan_pos + 1'b1 >= size) begin
                r_bnd <= 13'(scan_pos + 1'b1);
              end else begin
                scan_pos <= scan_pos + 1'b1;
                scan_k   <= scan_k + 3'd1;
                state    <= ST_SCAN;
              end
            end
          endcase
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    out_res.ok        = r_ok;
    out_res.deleted   = r_del;
    out_res.read_byte = r_byte;
    out_res.boundary  = r_bnd;
    out_res.cursor    = 13'(gap_front);
    out_res.text_size = 13'(size);
  end

endmodule

// File: hw/rtl/gap_buffer_text_engine_top.sv
// top level of the gap buffer text engine
//  channel  dir  payload
//  s_axis   in   cmd, data_byte, amount, position
//  m_axis   out  ok, deleted, read_byte, boundary, cursor, text_size
// simple commands go from the queue through ST_DONE to the result; reads also pass ST_SCAN and ST_SWAIT
// boundary searches look at up to 4 bytes, one per pass through ST_SCAN and ST_SWAIT
// a cursor move shifts one byte at a time across the gap, read in ST_MOVE and written in ST_MWR (memory port)
// rst is synchronous; the text memory is not cleared
// a two-entry queue takes items while a result waits on m_axis_tready
module gap_buffer_text_engine_top #(
  parameter int unsigned CAPACITY = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // cmd, data_byte, amount, position, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // ok, deleted, read_byte, boundary, cursor, text_size, pad
);

  gbte_pkg::item_t   in_item;
  gbte_pkg::item_t   q_item;
  gbte_pkg::result_t res;
  logic              q_valid;
  logic              q_ready;

  assign in_item.cmd       = gbte_pkg::cmd_t'(s_axis_tdata[2:0]);
  assign in_item.data_byte = s_axis_tdata[10:3];
  assign in_item.amount    = s_axis_tdata[23:11];
  assign in_item.position  = s_axis_tdata[36:24];

  gbte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  gbte_back #(.CAPACITY(CAPACITY)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {3'd0, res.text_size, res.cursor, res.boundary,
                         res.read_byte, res.deleted, res.ok};

endmodule

// File: hw/rtl/gbte_checker.sv
// port-level checks for the gap buffer text engine
module gbte_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // cursor never exceeds text size
  a_cur: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[47:35] <= m_axis_tdata[60:48])
    else $error("cursor beyond text size");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result after reset");

  // a result with ok set reports no deletion
  a_del: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[13:1] == 13'd0)
    else $error("ok and deleted both set");

endmodule

bind gap_buffer_text_engine_top gbte_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: verif/gap_buffer_text_engine_top_tb.sv
// self-checking testbench for the gap buffer text engine with a text model scoreboard
`timescale 1ns / 100ps

module gap_buffer_text_engine_top_tb;

  localparam int unsigned CAP = 4096;
  localparam int unsigned RANDOM_ITEMS = 1620;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 300;

  class edit_scoreboard;
    logic [7:0] store [CAP];
    int unsigned front, back, run_left;
    bit run_ok;
    gbte_pkg::result_t pending[$];
    int unsigned errors, results_seen;
    int unsigned cmd_hits [8];

    function void clear();
      front = 0;
      back = CAP;
      run_left = 0;
      run_ok = 0;
      pending.delete();
      errors = 0;
      results_seen = 0;
      foreach (cmd_hits[i]) cmd_hits[i] = 0;
    endfunction

    function int unsigned text_size();
      return front + (CAP - back);
    endfunction

    function logic [7:0] byte_at(int unsigned pos);
      if (pos >= text_size()) return 8'h00;
      if (pos < front) return store[pos];
      return store[pos + (back - front)];
    endfunction

    function bit cont(logic [7:0] b);
      return (b & 8'hC0) == 8'h80;
    endfunction

    function int unsigned prev_bound(int unsigned pos);
      int unsigned i;
      if (pos > text_size()) pos = text_size();
      if (pos == 0) return 0;
      i = pos;
      for (int k = 0; k < 4 && i > 0; k++) begin
        i--;
        if (!cont(byte_at(i))) return i;
      end
      return pos - 1;
    endfunction

    function int unsigned next_bound(int unsigned pos);
      int unsigned i;
      if (pos >= text_size()) return text_size();
      i = pos + 1;
      for (int k = 0; k < 4 && i < text_size(); k++) begin
        if (!cont(byte_at(i))) return i;
        i++;
      end
      return i;
    endfunction

    function bit move_to(int unsigned pos);
      int unsigned was;
      was = front;
      if (pos > text_size()) pos = text_size();
      while (front > pos) begin
        front--;
        back--;
        store[back] = store[front];
      end
      while (front < pos) begin
        store[front] = store[back];
        front++;
        back++;
      end
      return front != was;
    endfunction

    function void note_command(gbte_pkg::item_t it);
      gbte_pkg::result_t r;
      int unsigned n;
      r = '0;
      cmd_hits[it.cmd]++;
      case (it.cmd)
        gbte_pkg::CMD_INSERT: begin
          if (run_left == 0 && it.amount == 0) begin
            r.ok = 1'b1;
          end else begin
            if (run_left == 0) begin
              run_ok = it.amount <= (back - front);
              run_left = it.amount - 1;
            end else begin
              run_left--;
            end
            if (run_ok && front < back) begin
              store[front] = it.data_byte;
              front++;
            end
            r.ok = run_ok;
          end
        end
        gbte_pkg::CMD_DEL_BACK: begin
          n = (it.amount < front) ? it.amount : front;
          front -= n;
          r.deleted = 13'(n);
        end
        gbte_pkg::CMD_DEL_FWD: begin
          n = (it.amount < CAP - back) ? it.amount : CAP - back;
          back += n;
          r.deleted = 13'(n);
        end
        gbte_pkg::CMD_SET_CUR:  r.ok = move_to(it.position);
        gbte_pkg::CMD_READ:     r.read_byte = byte_at(it.position);
        gbte_pkg::CMD_PREV_BND: r.boundary = 13'(prev_bound(it.position));
        gbte_pkg::CMD_NEXT_BND: r.boundary = 13'(next_bound(it.position));
        default: ;
      endcase
      r.cursor = 13'(front);
      r.text_size = 13'(text_size());
      pending.push_back(r);
    endfunction

    function void check_result(gbte_pkg::result_t got);
      gbte_pkg::result_t exp;
      results_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.ok !== exp.ok)
        $display("%0t: ok exp %0d got %0d", $time, exp.ok, got.ok);
      if (got.deleted !== exp.deleted)
        $display("%0t: deleted exp %0d got %0d", $time, exp.deleted, got.deleted);
      if (got.read_byte !== exp.read_byte)
        $display("%0t: read_byte exp %h got %h", $time, exp.read_byte, got.read_byte);
      if (got.boundary !== exp.boundary)
        $display("%0t: boundary exp %0d got %0d", $time, exp.boundary, got.boundary);
      if (got.cursor !== exp.cursor)
        $display("%0t: cursor exp %0d got %0d", $time, exp.cursor, got.cursor);
      if (got.text_size !== exp.text_size)
        $display("%0t: text_size exp %0d got %0d", $time, exp.text_size, got.text_size);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;

  gap_buffer_text_engine_top #(.CAPACITY(CAP)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  edit_scoreboard sb;
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned items_in, idle_cycles, hold_left;
  bit hold_done;
  int unsigned gen_run_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (!hold_done && items_in >= 400) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // item monitor and watchdog
  always @(posedge clk) begin
    gbte_pkg::result_t r;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_command(gbte_pkg::item_t'({s_axis_tdata[2:0], s_axis_tdata[10:3],
                                           s_axis_tdata[23:11], s_axis_tdata[36:24]}));
        items_in <= items_in + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        r.ok        = m_axis_tdata[0];
        r.deleted   = m_axis_tdata[13:1];
        r.read_byte = m_axis_tdata[21:14];
        r.boundary  = m_axis_tdata[34:22];
        r.cursor    = m_axis_tdata[47:35];
        r.text_size = m_axis_tdata[60:48];
        sb.check_result(r);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send(gbte_pkg::cmd_t c, logic [7:0] d, logic [12:0] amt,
                      logic [12:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, pos, amt, d, c};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [7:0] rand_text_byte();
    if ($urandom_range(99) < 40) return 8'h80 | 8'($urandom_range(63));
    return 8'($urandom_range(255));
  endfunction

  task automatic random_item();
    int unsigned r, sz, len;
    r = $urandom_range(99);
    sz = sb.text_size();
    if (sz > 250 && r < 20) begin
      send(($urandom_range(1) != 0) ? gbte_pkg::CMD_DEL_BACK : gbte_pkg::CMD_DEL_FWD,
           8'($urandom), 13'($urandom_range(100, 4096)), 13'($urandom_range(0, 4096)));
    end else if (gen_run_left > 0 && r < 70) begin
      send(gbte_pkg::CMD_INSERT, rand_text_byte(), 13'($urandom_range(0, 4096)),
           13'($urandom_range(0, 4096)));
      gen_run_left--;
    end else if (gen_run_left == 0 && r < 35) begin
      len = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8);
      send(gbte_pkg::CMD_INSERT, rand_text_byte(), 13'(len), 13'($urandom_range(0, 4096)));
      if (len > 0) gen_run_left = len - 1;
    end else if (r < 45) begin
      send(gbte_pkg::CMD_DEL_BACK, 8'($urandom),
           13'(($urandom_range(9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 6)),
           13'($urandom_range(0, 4096)));
    end else if (r < 55) begin
      send(gbte_pkg::CMD_DEL_FWD, 8'($urandom),
           13'(($urandom_range(9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 6)),
           13'($urandom_range(0, 4096)));
    end else if (r < 67) begin
      send(gbte_pkg::CMD_SET_CUR, 8'($urandom), 13'($urandom_range(0, 4096)),
           13'(($urandom_range(9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, sz + 3)));
    end else if (r < 79) begin
      send(gbte_pkg::CMD_READ, 8'($urandom), 13'($urandom_range(0, 4096)),
           13'(($urandom_range(9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, sz + 2)));
    end else if (r < 87) begin
      send(gbte_pkg::CMD_PREV_BND, 8'($urandom), 13'($urandom_range(0, 4096)),
           13'(($urandom_range(9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, sz + 2)));
    end else if (r < 95) begin
      send(gbte_pkg::CMD_NEXT_BND, 8'($urandom), 13'($urandom_range(0, 4096)),
           13'(($urandom_range(9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, sz + 2)));
    end else begin
      send(gbte_pkg::CMD_NONE, 8'($urandom), 13'($urandom_range(0, 4096)),
           13'($urandom_range(0, 4096)));
    end
  endtask

  initial begin
    int unsigned settle;
    sb = new();
    sb.clear();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_in = 0;
    idle_cycles = 0;
    hold_left = 0;
    hold_done = 1'b0;
    gen_run_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-text corners, a utf-8 run, clamping, interrupted run
    send(gbte_pkg::CMD_READ,     8'h00, 13'd0,    13'd0);
    send(gbte_pkg::CMD_PREV_BND, 8'h00, 13'd0,    13'd4096);
    send(gbte_pkg::CMD_NEXT_BND, 8'h00, 13'd0,    13'd0);
    send(gbte_pkg::CMD_INSERT,   8'hFF, 13'd0,    13'd0);     // zero-length run
    send(gbte_pkg::CMD_INSERT,   8'h00, 13'd4,    13'd0);
    send(gbte_pkg::CMD_INSERT,   8'hE2, 13'd4096, 13'd4096);
    send(gbte_pkg::CMD_READ,     8'hFF, 13'd0,    13'd1);     // read inside a run
    send(gbte_pkg::CMD_INSERT,   8'h82, 13'd0,    13'd0);
    send(gbte_pkg::CMD_INSERT,   8'hAC, 13'd0,    13'd0);
    send(gbte_pkg::CMD_INSERT,   8'hC3, 13'd6,    13'd0);     // lead byte, five continuations
    for (int i = 0; i < 5; i++) send(gbte_pkg::CMD_INSERT, 8'h80 | 8'(i), 13'd0, 13'd0);
    send(gbte_pkg::CMD_PREV_BND, 8'h00, 13'd0,    13'd4096);
    send(gbte_pkg::CMD_NEXT_BND, 8'h00, 13'd0,    13'd4);
    send(gbte_pkg::CMD_PREV_BND, 8'h00, 13'd0,    13'd4);
    send(gbte_pkg::CMD_SET_CUR,  8'h00, 13'd0,    13'd2);
    send(gbte_pkg::CMD_SET_CUR,  8'h00, 13'd0,    13'd2);     // no move
    send(gbte_pkg::CMD_READ,     8'h00, 13'd0,    13'd4096);
    send(gbte_pkg::CMD_DEL_BACK, 8'h00, 13'd1,    13'd0);
    send(gbte_pkg::CMD_DEL_FWD,  8'h00, 13'd1,    13'd0);
    send(gbte_pkg::CMD_SET_CUR,  8'h00, 13'd0,    13'd4096);  // clamps to end
    send(gbte_pkg::CMD_SET_CUR,  8'h00, 13'd0,    13'd0);
    send(gbte_pkg::CMD_NONE,     8'hFF, 13'h1FFF, 13'h1FFF);
    send(gbte_pkg::CMD_DEL_FWD,  8'h00, 13'd4096, 13'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case (i * 4 / RANDOM_ITEMS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      random_item();
    end

    // finish any open run, then a run too long for the gap is refused
    while (gen_run_left > 0) begin
      send(gbte_pkg::CMD_INSERT, rand_text_byte(), 13'd0, 13'd0);
      gen_run_left--;
    end
    send(gbte_pkg::CMD_INSERT, 8'h41, 13'd1, 13'd0);
    send(gbte_pkg::CMD_INSERT, 8'h42, 13'd4096, 13'd0);
    for (int i = 0; i < 3; i++) send(gbte_pkg::CMD_INSERT, 8'h43, 13'd0, 13'd0);
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 50) begin
      @(posedge clk);
      settle++;
    end
    $display("run: %0d items in, %0d results checked, final text size %0d",
             items_in, sb.results_seen, sb.text_size());
    $display("commands: ins %0d delb %0d delf %0d mov %0d rd %0d prev %0d next %0d none %0d",
             sb.cmd_hits[0], sb.cmd_hits[1], sb.cmd_hits[2], sb.cmd_hits[3],
             sb.cmd_hits[4], sb.cmd_hits[5], sb.cmd_hits[6], sb.cmd_hits[7]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
